@@ design/u8u16_pkg.sv @@
// ---------------------------------------------------------------------------
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16LE block
// Holds the byte-class constants of UTF-8 lead bytes, the UTF-16 surrogate
// constants and the result group that one input item produces.
// ---------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  // Widths of the code point and of the pending-continuation counter.
  localparam int CodeW  = 21;
  localparam int PendW  = 2;
  localparam int GroupN = 4;

  // UTF-8 lead byte classes: (byte & mask) == code.
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] AsciiTop  = 8'h80;

  // Continuation payload and UTF-16 constants.
  localparam logic [7:0]       ContMask  = 8'h3F;
  localparam logic [CodeW-1:0] ReplChar  = 21'h00FFFD;
  localparam logic [CodeW-1:0] SuppBase  = 21'h010000;
  localparam logic [15:0]      HiSurr    = 16'hD800;
  localparam logic [15:0]      LoSurr    = 16'hDC00;
  localparam logic [15:0]      SurrMask  = 16'h03FF;

  // Byte counts of a result group.
  localparam logic [2:0] CntNone = 3'd0;
  localparam logic [2:0] CntBmp  = 3'd2;
  localparam logic [2:0] CntPair = 3'd4;

  // Output bytes caused by one input item, low byte of each unit first.
  typedef struct packed {
    logic [GroupN-1:0][7:0] bytes;
    logic [2:0]             count;
    logic                   ends;
  } u8u16_group_t;

endpackage

`default_nettype wire

@@ design/u8u16_decode.sv @@
// ---------------------------------------------------------------------------
// u8u16_decode: UTF-8 sequence decoder
// Holds the partial code point and the count of continuation bytes still
// expected, and turns each accepted byte into a group of 0, 2 or 4
// UTF-16LE output bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_decode
  import u8u16_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  output u8u16_group_t      group
);

  logic [CodeW-1:0] code_accum;
  logic [PendW-1:0] bytes_pending;
  logic [CodeW-1:0] code_accum_next;
  logic [PendW-1:0] bytes_pending_next;

  logic             emit;
  logic [CodeW-1:0] emit_code;
  logic [CodeW-1:0] cont_accum;
  logic [PendW-1:0] cont_pending;
  logic [CodeW-1:0] supp_off;
  logic [15:0]      unit_hi;
  logic [15:0]      unit_lo;
  logic             is_pair;

  // Sequence state and the single code point this byte may complete.
  always_comb begin
    code_accum_next    = code_accum;
    bytes_pending_next = bytes_pending;
    emit               = 1'b0;
    emit_code          = ReplChar;
    cont_accum         = {code_accum[CodeW-7:0], in_byte[5:0]};
    cont_pending       = bytes_pending - PendW'(1);
    if (bytes_pending == '0) begin
      if (in_byte < AsciiTop) begin
        emit      = 1'b1;
        emit_code = CodeW'(in_byte);
      end else if ((in_byte & Lead2Mask) == Lead2Code) begin
        code_accum_next    = CodeW'(in_byte[4:0]);
        bytes_pending_next = PendW'(1);
      end else if ((in_byte & Lead3Mask) == Lead3Code) begin
        code_accum_next    = CodeW'(in_byte[3:0]);
        bytes_pending_next = PendW'(2);
      end else if ((in_byte & Lead4Mask) == Lead4Code) begin
        code_accum_next    = CodeW'(in_byte[2:0]);
        bytes_pending_next = PendW'(3);
      end else begin
        emit      = 1'b1;
        emit_code = ReplChar;
      end
    end else begin
      code_accum_next    = cont_accum;
      bytes_pending_next = cont_pending;
      if (cont_pending == '0) begin
        emit            = 1'b1;
        emit_code       = cont_accum;
        code_accum_next = '0;
      end
    end
    // The string ends here: an open sequence becomes one replacement.
    if (in_last) begin
      if (bytes_pending_next != '0) begin
        emit      = 1'b1;
        emit_code = ReplChar;
      end
      code_accum_next    = '0;
      bytes_pending_next = '0;
    end
  end

  // UTF-16 units: a surrogate pair above the basic plane.
  always_comb begin
    is_pair  = (emit_code >= SuppBase);
    supp_off = emit_code - SuppBase;
    unit_hi  = HiSurr + 16'(supp_off >> 10);
    unit_lo  = LoSurr + (supp_off[15:0] & SurrMask);
    group.ends = in_last;
    if (!emit) begin
      group.count = CntNone;
      group.bytes = '0;
    end else if (is_pair) begin
      group.count = CntPair;
      group.bytes = {unit_lo[15:8], unit_lo[7:0], unit_hi[15:8], unit_hi[7:0]};
    end else begin
      group.count = CntBmp;
      group.bytes = {16'h0000, emit_code[15:8], emit_code[7:0]};
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum    <= '0;
      bytes_pending <= '0;
    end else if (step) begin
      code_accum    <= code_accum_next;
      bytes_pending <= bytes_pending_next;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_to_utf16le_bytes.sv @@
// ---------------------------------------------------------------------------
// utf8_to_utf16le_bytes: streaming UTF-8 to UTF-16LE byte transcoder
// Takes one UTF-8 byte per item and sends the UTF-16LE bytes it causes,
// one byte per item on the output.
// ---------------------------------------------------------------------------
// The block sends one output byte per cycle from a result register while
// out_ready is high. An input item causes two bytes for a basic plane
// character or a replacement, four for a surrogate pair, and none for a
// lead or continuation byte that completes nothing. The next input item is
// taken in the same cycle that the last byte of the current group is taken,
// so the output has no gap when the next item is waiting and completes a
// character. Invalid leads and strings that end inside a sequence give
// U+FFFD; run_last marks the last byte caused by an input item and
// stream_end the last byte of the string.
`default_nettype none

module utf8_to_utf16le_bytes
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            stream_end
);

  u8u16_group_t dec_group;
  u8u16_group_t grp;
  logic         busy;
  logic [1:0]   idx;
  logic         in_take;
  logic         out_take;

  // Decoder with the sequence state.
  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (in_take),
    .in_byte (in_byte),
    .in_last (in_last),
    .group   (dec_group)
  );

  // Output byte selection from the result register.
  always_comb begin
    out_valid  = busy;
    out_byte   = grp.bytes[idx];
    run_last   = ({1'b0, idx} == (grp.count - 3'd1));
    stream_end = run_last & grp.ends;
    out_take   = out_valid & out_ready;
    in_ready   = !busy || (out_ready && run_last);
    in_take    = in_valid & in_ready;
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_take && dec_group.count != CntNone) begin
      grp <= dec_group;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_take && dec_group.count != CntNone) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_take && run_last) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (out_take) begin
      idx <= idx + 2'd1;
    end
  end

  // A group that is not finished keeps the output valid.
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    (out_take && !run_last) |=> out_valid)
    else $error("output group dropped before its last byte");

  // A waiting group always holds two or four bytes.
  a_group_size: assert property (@(posedge clk) disable iff (rst)
    busy |-> (grp.count == CntBmp || grp.count == CntPair))
    else $error("result group has an illegal byte count");

  // The byte index stays inside the group.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < grp.count))
    else $error("byte index beyond the result group");

  // With no group waiting the index is back at the first byte.
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (idx == 2'd0))
    else $error("byte index not cleared while idle");

endmodule

`default_nettype wire

@@ dv/utf16le_byte_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf16le_byte_checker: watches both channels of the UTF-8 to UTF-16LE block
// Works out the UTF-16LE bytes due for every accepted UTF-8 item and compares
// every accepted output item with the oldest byte still due, field by field.
// ---------------------------------------------------------------------------
module utf16le_byte_checker
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       stream_end,
  output int         fail_count,
  output int         bytes_owed
);

  typedef struct packed {
    logic [7:0] data;
    logic       unit_end;
    logic       str_end;
  } u16_byte_t;

  // Bytes still due on the output, oldest first.
  u16_byte_t due_q[$];
  // Bytes caused by the item being decoded.
  u16_byte_t step_q[$];
  u16_byte_t got_due;

  // Decoder state: partial code point and continuation bytes still to come.
  logic [CodeW-1:0] cp_acc;
  logic [PendW-1:0] cont_left;

  initial begin
    fail_count = 0;
    bytes_owed = 0;
  end

  // Appends one 16-bit unit, low byte first.
  function automatic void add_unit(input logic [15:0] unit);
    u16_byte_t b;
    b = '0;
    b.data = unit[7:0];
    step_q = {step_q, b};
    b.data = unit[15:8];
    step_q = {step_q, b};
  endfunction

  // Supplementary code points are split into a surrogate pair.
  function automatic void add_code(input logic [CodeW-1:0] cp);
    logic [CodeW-1:0] off;
    if (cp >= SuppBase) begin
      off = cp - SuppBase;
      add_unit(HiSurr + 16'(off >> 10));
      add_unit(LoSurr + (16'(off) & SurrMask));
    end else begin
      add_unit(cp[15:0]);
    end
  endfunction

  // Decodes one UTF-8 byte and queues the UTF-16LE bytes it causes.
  function automatic void transcode_byte(input logic [7:0] b, input logic lst);
    int n;
    step_q.delete();
    if (cont_left == '0) begin
      if (b < AsciiTop) begin
        add_code(CodeW'(b));
      end else if ((b & Lead2Mask) == Lead2Code) begin
        cp_acc    = CodeW'(b & ~Lead2Mask);
        cont_left = PendW'(1);
      end else if ((b & Lead3Mask) == Lead3Code) begin
        cp_acc    = CodeW'(b & ~Lead3Mask);
        cont_left = PendW'(2);
      end else if ((b & Lead4Mask) == Lead4Code) begin
        cp_acc    = CodeW'(b & ~Lead4Mask);
        cont_left = PendW'(3);
      end else begin
        add_code(ReplChar);
      end
    end else begin
      // Continuations are taken without any check of their top bits.
      cp_acc    = (cp_acc << 6) | CodeW'(b & ContMask);
      cont_left = cont_left - PendW'(1);
      if (cont_left == '0) begin
        add_code(cp_acc);
        cp_acc = '0;
      end
    end
    // A string that ends inside a sequence gives one replacement character.
    if (lst) begin
      if (cont_left != '0) add_code(ReplChar);
      cp_acc    = '0;
      cont_left = '0;
    end
    n = step_q.size();
    if (n > 0) begin
      step_q[n-1].unit_end = 1'b1;
      step_q[n-1].str_end  = lst;
    end
    due_q = {due_q, step_q};
  endfunction

  // Output items are checked before the input item of the same edge is
  // decoded, since no result can come out in the cycle its item goes in.
  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      cp_acc    = '0;
      cont_left = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("output item with none due: out_byte %02h", out_byte);
          fail_count++;
        end else begin
          got_due = due_q.pop_front();
          if (out_byte !== got_due.data) begin
            $error("out_byte: expected %02h, actual %02h", got_due.data, out_byte);
            fail_count++;
          end
          if (run_last !== got_due.unit_end) begin
            $error("run_last: expected %0b, actual %0b", got_due.unit_end, run_last);
            fail_count++;
          end
          if (stream_end !== got_due.str_end) begin
            $error("stream_end: expected %0b, actual %0b", got_due.str_end, stream_end);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) transcode_byte(in_byte, in_last);
    end
    bytes_owed = due_q.size();
  end

endmodule

@@ dv/tb_utf8_to_utf16le_bytes.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_to_utf16le_bytes: testbench for the UTF-8 to UTF-16LE transcoder
// Sends directed UTF-8 strings and then random strings of well-formed,
// truncated and invalid sequences, with random idling on both channels and
// one long output stall; the checker compares every output item.
// ---------------------------------------------------------------------------
module tb_utf8_to_utf16le_bytes;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;

  int fail_count;
  int bytes_owed;
  int items_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit held = 1'b0;

  // Directed strings: extremes, every sequence length, invalid leads and
  // strings that end inside a sequence. Bit 8 marks the final byte.
  localparam logic [8:0] DirectedBytes [24] = '{
    9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0F8, 9'h0FF, 9'h1C3, 9'h0E2, 9'h182,
    9'h0E0, 9'h041, 9'h17F
  };

  always #5 clk = ~clk;

  utf8_to_utf16le_bytes u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

  utf16le_byte_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  // Offers one item, sometimes after a random gap, and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    bit hit;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    do begin
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
    end while (!hit);
    items_sent++;
  endtask

  // Sends one character: mostly well-formed with random payload, sometimes
  // a random byte or a sequence cut short.
  task automatic send_char(input bit lst);
    int kind;
    int len;
    int n;
    logic [7:0] seq [4];
    kind = $urandom_range(0, 19);
    if (kind < 7) len = 1;
    else if (kind < 10) len = 2;
    else if (kind < 13) len = 3;
    else if (kind < 16) len = 4;
    else if (kind < 18) len = 0;
    else len = $urandom_range(2, 4);
    n = (len == 0) ? 1 : len;
    if (kind >= 18) n = $urandom_range(1, len - 1);
    case (len)
      0:       seq[0] = 8'($urandom);
      1:       seq[0] = {1'b0, 7'($urandom)};
      2:       seq[0] = {3'b110, 5'($urandom)};
      3:       seq[0] = {4'b1110, 4'($urandom)};
      default: seq[0] = {5'b11110, 3'($urandom)};
    endcase
    for (int i = 1; i < n; i++) begin
      seq[i] = ($urandom_range(0, 15) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
    end
    for (int i = 0; i < n; i++) send_byte(seq[i], lst && (i == n - 1));
  endtask

  // Output side: random stall bursts, plus one long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 120;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Stimulus and verdict.
  initial begin
    int nchars;
    int wait_cnt;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_byte  <= '0;
    in_last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);

    while (items_sent < 365) begin
      // Once, stall the output for long while ASCII keeps coming in.
      if (!held && items_sent >= 150) begin
        held     = 1'b1;
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_byte({1'b0, 7'($urandom)}, i == 29);
        quiet = 1'b0;
      end
      // The last part of the run has no idling on either side.
      if (items_sent >= 340) quiet = 1'b1;
      nchars = $urandom_range(1, 12);
      for (int c = 0; c < nchars; c++) send_char(c == nchars - 1);
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (bytes_owed != 0 && wait_cnt < 4000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
